// ===== rtl/core/qpc_pkg.sv =====
// Package with shared types, codes and reset constants of the position controller.
`timescale 1ns / 1ps

package qpc_pkg;

  localparam int unsigned CountWidthDef = 32;
  localparam int unsigned DutyWidthDef  = 16;

  localparam int unsigned PosWidth   = 32;
  localparam int unsigned TgtWidth   = 32;
  localparam int unsigned ThrWidth   = 8;
  localparam int unsigned DutyFieldW = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [ThrWidth-1:0] ArriveThrRst = 8'd2;
  localparam logic [ThrWidth-1:0] FarThrRst    = 8'd8;
  localparam logic [ThrWidth-1:0] NearThrRst   = 8'd4;

  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_HOME  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ARRIVE_THR = 3'd0,
    CFG_FAR_THR    = 3'd1,
    CFG_NEAR_THR   = 3'd2,
    CFG_FAST_DUTY  = 3'd3,
    CFG_MID_DUTY   = 3'd4,
    CFG_SLOW_DUTY  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [ThrWidth-1:0]   arrive_thr;
    logic [ThrWidth-1:0]   far_thr;
    logic [ThrWidth-1:0]   near_thr;
    logic [DutyFieldW-1:0] fast_duty;
    logic [DutyFieldW-1:0] mid_duty;
    logic [DutyFieldW-1:0] slow_duty;
  } cfg_t;

  typedef struct packed {
    logic move;
    logic dir_cw;
    logic brake;
    logic arrived;
  } ctrl_t;

endpackage

// ===== rtl/core/qpc_step.sv =====
// Next-state logic of the controller for one input word.
`timescale 1ns / 1ps

module qpc_step import qpc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef,
  parameter int unsigned DUTY_WIDTH  = DutyWidthDef
) (
  input  logic [1:0]             op_i,
  input  logic                   edge_on_b_i,
  input  logic                   other_level_i,
  input  logic [TgtWidth-1:0]    goal_pos_i,
  input  cfg_t                   cfg_i,
  input  logic [COUNT_WIDTH-1:0] count_i,
  input  logic [COUNT_WIDTH-1:0] target_i,
  input  logic [DUTY_WIDTH-1:0]  duty_i,
  input  ctrl_t                  ctrl_i,
  output logic [COUNT_WIDTH-1:0] count_o,
  output logic [COUNT_WIDTH-1:0] target_o,
  output logic [DUTY_WIDTH-1:0]  duty_o,
  output ctrl_t                  ctrl_o
);

  logic                   up;
  logic [COUNT_WIDTH-1:0] err;
  logic                   neg;
  logic [COUNT_WIDTH-1:0] mag;
  logic [DutyFieldW-1:0]  sel_duty;
  logic signed [63:0]     tgt_ext;

  assign up      = edge_on_b_i ? !other_level_i : other_level_i;
  assign err     = target_i - count_i;
  assign neg     = err[COUNT_WIDTH-1];
  assign mag     = neg ? (~err + COUNT_WIDTH'(1)) : err;
  assign tgt_ext = 64'(signed'(goal_pos_i));

  always_comb begin
    priority if (mag >= COUNT_WIDTH'(cfg_i.far_thr)) begin
      sel_duty = cfg_i.fast_duty;
    end else if (mag >= COUNT_WIDTH'(cfg_i.near_thr)) begin
      sel_duty = cfg_i.mid_duty;
    end else begin
      sel_duty = cfg_i.slow_duty;
    end
  end

  always_comb begin
    count_o        = count_i;
    target_o       = target_i;
    duty_o         = duty_i;
    ctrl_o         = ctrl_i;
    ctrl_o.arrived = 1'b0;
    unique case (op_e'(op_i))
      OP_EDGE: begin
        count_o = up ? (count_i + COUNT_WIDTH'(1)) : (count_i - COUNT_WIDTH'(1));
      end
      OP_START: begin
        target_o    = tgt_ext[COUNT_WIDTH-1:0];
        ctrl_o.move = 1'b1;
      end
      OP_TICK: begin
        if (ctrl_i.move) begin
          if (mag <= COUNT_WIDTH'(cfg_i.arrive_thr)) begin
            duty_o         = '0;
            ctrl_o.brake   = 1'b1;
            ctrl_o.move    = 1'b0;
            ctrl_o.arrived = 1'b1;
          end else begin
            duty_o        = DUTY_WIDTH'(sel_duty);
            ctrl_o.brake  = 1'b0;
            ctrl_o.dir_cw = !neg;
          end
        end
      end
      OP_HOME: begin
        duty_o       = '0;
        ctrl_o.brake = 1'b1;
        count_o      = '0;
        ctrl_o.move  = 1'b0;
      end
      default: begin
        count_o = count_i;
      end
    endcase
  end

endmodule

// ===== rtl/core/quadrature_position_controller_unit.sv =====
// Top level of the quadrature encoder position controller.
//
//   Channel   Handshake                   Payload
//   in        in_valid_i / in_stall_o     op, edge_on_b, other_level, goal_pos
//   out       out_valid_o / out_stall_i   position_out, direction_cw, brake_on,
//                                         duty_out, moving, arrived
//   cfg       cfg_we_i                    cfg_idx_i, cfg_data_i
//
// Each word passes through the input register and then the result register, and one
// word is taken every cycle while the output is not stalled.
// The step logic is combinational, so the state update does not limit the throughput.
// Reset returns the state and the configuration to their reset values and clears
// both valid flags.
// A stall on the output holds the result and, once the input register is full, the input.
`timescale 1ns / 1ps

module quadrature_position_controller_unit import qpc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef,
  parameter int unsigned DUTY_WIDTH  = DutyWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            op_i,
  input  logic                  edge_on_b_i,
  input  logic                  other_level_i,
  input  logic [TgtWidth-1:0]   goal_pos_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PosWidth-1:0]   position_out_o,
  output logic                  direction_cw_o,
  output logic                  brake_on_o,
  output logic [DutyFieldW-1:0] duty_out_o,
  output logic                  moving_o,
  output logic                  arrived_o
);

  cfg_t cfg_q;

  logic                 in_valid_q;
  logic [1:0]           op_q;
  logic                 edge_on_b_q;
  logic                 other_level_q;
  logic [TgtWidth-1:0]  goal_pos_q;

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] target_q, target_d;
  logic [DUTY_WIDTH-1:0]  duty_q, duty_d;
  ctrl_t                  ctrl_q, ctrl_d;

  logic                  out_valid_q;
  logic [PosWidth-1:0]   pos_out_q;
  logic [DutyFieldW-1:0] duty_out_q;
  ctrl_t                 ctrl_out_q;

  logic               advance;
  logic               in_take;
  logic signed [63:0] count_ext;
  logic [31:0]        duty_ext;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arrive_thr <= ArriveThrRst;
      cfg_q.far_thr    <= FarThrRst;
      cfg_q.near_thr   <= NearThrRst;
      cfg_q.fast_duty  <= '0;
      cfg_q.mid_duty   <= '0;
      cfg_q.slow_duty  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ARRIVE_THR: cfg_q.arrive_thr <= cfg_data_i[ThrWidth-1:0];
        CFG_FAR_THR:    cfg_q.far_thr    <= cfg_data_i[ThrWidth-1:0];
        CFG_NEAR_THR:   cfg_q.near_thr   <= cfg_data_i[ThrWidth-1:0];
        CFG_FAST_DUTY:  cfg_q.fast_duty  <= cfg_data_i;
        CFG_MID_DUTY:   cfg_q.mid_duty   <= cfg_data_i;
        CFG_SLOW_DUTY:  cfg_q.slow_duty  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q          <= op_i;
      edge_on_b_q   <= edge_on_b_i;
      other_level_q <= other_level_i;
      goal_pos_q    <= goal_pos_i;
    end
  end

  qpc_step #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .DUTY_WIDTH (DUTY_WIDTH)
  ) u_step (
    .op_i          (op_q),
    .edge_on_b_i   (edge_on_b_q),
    .other_level_i (other_level_q),
    .goal_pos_i    (goal_pos_q),
    .cfg_i         (cfg_q),
    .count_i       (count_q),
    .target_i      (target_q),
    .duty_i        (duty_q),
    .ctrl_i        (ctrl_q),
    .count_o       (count_d),
    .target_o      (target_d),
    .duty_o        (duty_d),
    .ctrl_o        (ctrl_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      target_q       <= '0;
      duty_q         <= '0;
      ctrl_q.move    <= 1'b0;
      ctrl_q.dir_cw  <= 1'b1;
      ctrl_q.brake   <= 1'b1;
      ctrl_q.arrived <= 1'b0;
    end else if (advance) begin
      count_q  <= count_d;
      target_q <= target_d;
      duty_q   <= duty_d;
      ctrl_q   <= ctrl_d;
    end
  end

  assign count_ext = 64'(signed'(count_d));
  assign duty_ext  = 32'(duty_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pos_out_q  <= count_ext[PosWidth-1:0];
      duty_out_q <= duty_ext[DutyFieldW-1:0];
      ctrl_out_q <= ctrl_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_out_o = pos_out_q;
  assign direction_cw_o = ctrl_out_q.dir_cw;
  assign brake_on_o     = ctrl_out_q.brake;
  assign duty_out_o     = duty_out_q;
  assign moving_o       = ctrl_out_q.move;
  assign arrived_o      = ctrl_out_q.arrived;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the quadrature encoder position controller unit.
`timescale 1ns / 1ps

module tb_top;
  import qpc_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpareIdx = CfgIdxW'(CFG_SLOW_DUTY + 1);
  localparam logic [CfgIdxW-1:0] CfgTopIdx   = '1;
  localparam int unsigned        PhaseItems  = 250;

  typedef struct packed {
    op_e                 op;
    logic                edge_on_b;
    logic                other_level;
    logic [TgtWidth-1:0] target;
  } motor_cmd_t;

  typedef struct packed {
    logic [PosWidth-1:0]   position;
    logic                  dir_cw;
    logic                  brake;
    logic [DutyFieldW-1:0] duty;
    logic                  moving;
    logic                  arrived;
  } motor_status_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_PERIODIC,
    STALL_BLOCKS
  } stall_style_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            op_i = '0;
  logic                  edge_on_b_i = 1'b0;
  logic                  other_level_i = 1'b0;
  logic [TgtWidth-1:0]   goal_pos_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PosWidth-1:0]   position_out_o;
  logic                  direction_cw_o;
  logic                  brake_on_o;
  logic [DutyFieldW-1:0] duty_out_o;
  logic                  moving_o;
  logic                  arrived_o;

  motor_cmd_t    pending_cmds[$];
  motor_status_t predicted_status[$];
  int unsigned   words_sent = 0;
  int unsigned   words_taken = 0;
  int unsigned   items_queued = 0;
  int unsigned   mismatches = 0;
  int unsigned   burst_left = 1;
  int unsigned   gap_left = 0;
  int unsigned   stall_left = 0;
  stall_style_e  stall_style = STALL_NONE;

  // Shadow of the controller state and its settings.
  cfg_t                  ctl_cfg;
  logic [PosWidth-1:0]   enc_count;
  logic [PosWidth-1:0]   goal_count;
  logic                  armed;
  logic                  cw_set;
  logic                  brake_set;
  logic [DutyFieldW-1:0] drive_duty;

  // Count the stimulus generator expects after the words queued so far.
  logic [PosWidth-1:0]   plan_pos = '0;

  always #2 clk_i = ~clk_i;

  quadrature_position_controller_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .edge_on_b_i   (edge_on_b_i),
    .other_level_i (other_level_i),
    .goal_pos_i    (goal_pos_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .position_out_o(position_out_o),
    .direction_cw_o(direction_cw_o),
    .brake_on_o    (brake_on_o),
    .duty_out_o    (duty_out_o),
    .moving_o      (moving_o),
    .arrived_o     (arrived_o)
  );

  function automatic motor_status_t advance_controller(motor_cmd_t cmd);
    logic [PosWidth-1:0] err;
    logic [PosWidth-1:0] mag;
    logic                neg;
    logic                up;
    motor_status_t       st;
    st.arrived = 1'b0;
    case (cmd.op)
      OP_EDGE: begin
        up = cmd.edge_on_b ? !cmd.other_level : cmd.other_level;
        enc_count = up ? enc_count + 1'b1 : enc_count - 1'b1;
      end
      OP_START: begin
        goal_count = cmd.target;
        armed = 1'b1;
      end
      OP_TICK: begin
        if (armed) begin
          err = goal_count - enc_count;
          neg = err[PosWidth-1];
          mag = neg ? -err : err;
          if (mag <= PosWidth'(ctl_cfg.arrive_thr)) begin
            drive_duty = '0;
            brake_set = 1'b1;
            armed = 1'b0;
            st.arrived = 1'b1;
          end else begin
            brake_set = 1'b0;
            cw_set = !neg;
            if (mag >= PosWidth'(ctl_cfg.far_thr)) begin
              drive_duty = ctl_cfg.fast_duty;
            end else if (mag >= PosWidth'(ctl_cfg.near_thr)) begin
              drive_duty = ctl_cfg.mid_duty;
            end else begin
              drive_duty = ctl_cfg.slow_duty;
            end
          end
        end
      end
      default: begin
        drive_duty = '0;
        brake_set = 1'b1;
        enc_count = '0;
        armed = 1'b0;
      end
    endcase
    st.position = enc_count;
    st.dir_cw = cw_set;
    st.brake = brake_set;
    st.duty = drive_duty;
    st.moving = armed;
    return st;
  endfunction

  task automatic check_field(string name, logic [PosWidth-1:0] want, logic [PosWidth-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_cmd(op_e op, logic [TgtWidth-1:0] tgt, logic on_b, logic lvl);
    motor_cmd_t c;
    c.op = op;
    c.target = tgt;
    c.edge_on_b = on_b;
    c.other_level = lvl;
    pending_cmds.push_back(c);
    items_queued++;
    if (op == OP_HOME) begin
      plan_pos = '0;
    end else if (op == OP_EDGE) begin
      plan_pos = (on_b ? !lvl : lvl) ? plan_pos + 1'b1 : plan_pos - 1'b1;
    end
  endtask

  task automatic push_edge(logic on_b, logic lvl);
    push_cmd(OP_EDGE, $urandom, on_b, lvl);
  endtask

  task automatic push_step(bit up);
    logic on_b;
    on_b = 1'($urandom_range(0, 1));
    push_edge(on_b, on_b ? !up : up);
  endtask

  task automatic push_start(logic [TgtWidth-1:0] tgt);
    push_cmd(OP_START, tgt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic push_tick();
    push_cmd(OP_TICK, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic push_home();
    push_cmd(OP_HOME, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle();
    while (words_taken != items_queued || predicted_status.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_ARRIVE_THR: ctl_cfg.arrive_thr = data[ThrWidth-1:0];
      CFG_FAR_THR:    ctl_cfg.far_thr = data[ThrWidth-1:0];
      CFG_NEAR_THR:   ctl_cfg.near_thr = data[ThrWidth-1:0];
      CFG_FAST_DUTY:  ctl_cfg.fast_duty = data;
      CFG_MID_DUTY:   ctl_cfg.mid_duty = data;
      CFG_SLOW_DUTY:  ctl_cfg.slow_duty = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Waits for the pipeline to drain, then rewrites every configuration register. Threshold
  // writes carry random upper bits that the block has to drop.
  task automatic load_controls(logic [ThrWidth-1:0] arrive, logic [ThrWidth-1:0] far,
                               logic [ThrWidth-1:0] near, logic [DutyFieldW-1:0] fast,
                               logic [DutyFieldW-1:0] mid, logic [DutyFieldW-1:0] slow);
    wait_idle();
    cfg_write(CFG_ARRIVE_THR, {(CfgDataW - ThrWidth)'($urandom), arrive});
    cfg_write(CFG_FAR_THR, {(CfgDataW - ThrWidth)'($urandom), far});
    cfg_write(CFG_NEAR_THR, {(CfgDataW - ThrWidth)'($urandom), near});
    cfg_write(CFG_FAST_DUTY, fast);
    cfg_write(CFG_MID_DUTY, mid);
    cfg_write(CFG_SLOW_DUTY, slow);
    cfg_write(CfgSpareIdx, CfgDataW'($urandom));
    cfg_write(CfgTopIdx, CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly complete moves: a start near the current count, edges walking
  // toward it with ticks in between, and a few trailing ticks; also homes and random words.
  task automatic run_move_mix(int unsigned n_items);
    int unsigned         stop_at;
    int unsigned         span;
    logic [TgtWidth-1:0] goal;
    bit                  up;
    stop_at = items_queued + n_items;
    while (items_queued < stop_at) begin
      case ($urandom_range(0, 9))
        8: push_home();
        9: begin
          repeat ($urandom_range(1, 8)) begin
            push_cmd(op_e'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
          end
        end
        default: begin
          span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 24);
          up = 1'($urandom_range(0, 1));
          goal = up ? plan_pos + span : plan_pos - span;
          if ($urandom_range(0, 7) == 0) begin
            goal = $urandom;
          end
          push_start(goal);
          repeat (span + $urandom_range(0, 6)) begin
            if ($urandom_range(0, 1) == 0) begin
              push_tick();
            end
            if ($urandom_range(0, 19) == 0) begin
              push_start(goal + $urandom_range(0, 8) - 4);
            end
            push_step(($urandom_range(0, 7) == 0) ? !up : up);
          end
          repeat ($urandom_range(1, 3)) push_tick();
        end
      endcase
    end
  endtask

  always @(negedge clk_i) begin
    motor_cmd_t c;
    if (in_valid_i && words_taken != words_sent) begin
      // The current word has not been taken yet and stays on the bus.
    end else if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_cmds.size() > 0) begin
      c = pending_cmds.pop_front();
      op_i <= c.op;
      edge_on_b_i <= c.edge_on_b;
      other_level_i <= c.other_level;
      goal_pos_i <= c.target;
      in_valid_i <= 1'b1;
      words_sent <= words_sent + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_style <= stall_style_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_COIN:     out_stall_i <= 1'($urandom_range(0, 1));
      STALL_PERIODIC: out_stall_i <= (stall_left % 3 == 0);
      default:        out_stall_i <= stall_left[3];
    endcase
  end

  always @(posedge clk_i) begin
    motor_cmd_t    c;
    motor_status_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        c.op = op_e'(op_i);
        c.edge_on_b = edge_on_b_i;
        c.other_level = other_level_i;
        c.target = goal_pos_i;
        predicted_status.push_back(advance_controller(c));
        words_taken <= words_taken + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (predicted_status.size() == 0) begin
          $error("result word arrived with no prediction pending");
          mismatches++;
        end else begin
          want = predicted_status.pop_front();
          check_field("position_out", want.position, position_out_o);
          check_field("direction_cw", PosWidth'(want.dir_cw), PosWidth'(direction_cw_o));
          check_field("brake_on", PosWidth'(want.brake), PosWidth'(brake_on_o));
          check_field("duty_out", PosWidth'(want.duty), PosWidth'(duty_out_o));
          check_field("moving", PosWidth'(want.moving), PosWidth'(moving_o));
          check_field("arrived", PosWidth'(want.arrived), PosWidth'(arrived_o));
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    ctl_cfg.arrive_thr = ArriveThrRst;
    ctl_cfg.far_thr = FarThrRst;
    ctl_cfg.near_thr = NearThrRst;
    ctl_cfg.fast_duty = '0;
    ctl_cfg.mid_duty = '0;
    ctl_cfg.slow_duty = '0;
    enc_count = '0;
    goal_count = '0;
    armed = 1'b0;
    cw_set = 1'b1;
    brake_set = 1'b1;
    drive_duty = '0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: an idle tick, then a move driven with zero duty.
    push_tick();
    push_start(32'd10);
    push_tick();

    load_controls(8'd2, 8'd8, 8'd4, 16'hFFFF, 16'h5A5A, 16'h0001);
    push_home();
    push_edge(1'b0, 1'b0);
    push_edge(1'b0, 1'b1);
    push_edge(1'b1, 1'b0);
    push_edge(1'b1, 1'b1);
    push_edge(1'b0, 1'b0);
    // From a count of -1 this target gives the most negative error.
    push_start(32'h7FFF_FFFF);
    push_tick();
    push_start(32'h8000_0000);
    push_tick();
    push_home();
    push_start(32'h7FFF_FFFF);
    push_tick();
    push_start(32'd6);
    push_tick();
    push_start(-32'sd3);
    push_tick();
    push_start(32'd2);
    push_tick();
    push_tick();
    push_start(-32'sd2);
    push_tick();
    push_start(32'd50);
    push_home();
    push_tick();

    load_controls(8'd3, 8'd20, 8'd10, DutyFieldW'($urandom), DutyFieldW'($urandom),
                  DutyFieldW'($urandom));
    run_move_mix(PhaseItems);
    load_controls(8'd0, 8'd0, 8'd0, 16'hFFFF, 16'h0000, 16'hFFFF);
    run_move_mix(PhaseItems);
    load_controls(8'd255, 8'd255, 8'd255, 16'h0000, 16'hFFFF, 16'h8000);
    run_move_mix(PhaseItems);
    // Near above far and arrive above far.
    load_controls(8'd10, 8'd5, 8'd30, 16'h1234, 16'hFEDC, 16'h00FF);
    run_move_mix(PhaseItems);
    load_controls(ThrWidth'($urandom_range(0, 15)), ThrWidth'($urandom_range(0, 255)),
                  ThrWidth'($urandom_range(0, 60)), DutyFieldW'($urandom),
                  DutyFieldW'($urandom), DutyFieldW'($urandom));
    run_move_mix(PhaseItems);
    load_controls(ThrWidth'($urandom_range(0, 15)), ThrWidth'($urandom_range(0, 60)),
                  ThrWidth'($urandom_range(0, 255)), DutyFieldW'($urandom),
                  DutyFieldW'($urandom), DutyFieldW'($urandom));
    run_move_mix(PhaseItems);

    wait_idle();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== quadrature_position_controller_unit.f =====
rtl/core/qpc_pkg.sv
rtl/core/qpc_step.sv
rtl/core/quadrature_position_controller_unit.sv
verif/tb_top.sv
